// ===== rtl/xcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xcd_pkg
// Shared constants, register indexes and types of the command frame receiver.
// ----------------------------------------------------------------------------
package xcd_pkg;

    // Payload size limits
    localparam int unsigned XCD_MAX_PAYLOAD  = 32;
    localparam int unsigned XCD_RESULT_LIMIT = 32;

    // Configuration port
    localparam int unsigned CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_MODE_CODE    = 3'd0;
    localparam t_cfg_idx REG_SERVO_CODE   = 3'd1;
    localparam t_cfg_idx REG_GAIN_CODE    = 3'd2;
    localparam t_cfg_idx REG_MODE_LENGTH  = 3'd3;
    localparam t_cfg_idx REG_SERVO_LENGTH = 3'd4;
    localparam t_cfg_idx REG_GAIN_LENGTH  = 3'd5;

    // Register reset values
    localparam logic [7:0] RST_MODE_CODE  = 8'd1;
    localparam logic [7:0] RST_SERVO_CODE = 8'd2;
    localparam logic [7:0] RST_GAIN_CODE  = 8'd3;
    localparam logic [5:0] RST_LENGTH     = 6'd8;

    // Frame kinds
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_MODE  = 2'd0;
    localparam t_kind KIND_SERVO = 2'd1;
    localparam t_kind KIND_GAIN  = 2'd2;

    // Result status codes
    localparam logic ST_GOOD    = 1'b0;
    localparam logic ST_BAD_SUM = 1'b1;

    // Decoded configuration seen by the receive control
    typedef struct packed {
        logic       hit;   // received byte matches a start code
        t_kind      kind;  // kind selected by that start code
        logic [5:0] len;   // clamped payload length of the open kind
    } t_cfg_view;

    // Clamp a length register to the range 1..cap
    function automatic logic [5:0] clamp_len(input logic [5:0] len, input logic [5:0] cap);
        logic [5:0] v;
        v = (len == 6'd0) ? 6'd1 : len;
        if (v > cap) begin
            v = cap;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/xor_checked_command_deframer.sv =====
`default_nettype none
// After a good frame's checksum transfer, each payload byte is read from the store
// (S_RD), then loaded into the result register (S_LD) once the result slot is free.
// Throughput: one byte per cycle while a frame is received, but the checksum byte waits
// for a free result slot; input is held off while a good frame is emitted.
// Reset: synchronous, active low; clears control registers, not payload registers or store.
// ----------------------------------------------------------------------------
// xor_checked_command_deframer
// Start code / length / XOR checksum frame receiver with buffered payload.
// ----------------------------------------------------------------------------
module xor_checked_command_deframer #(
    parameter int unsigned MAX_PAYLOAD = xcd_pkg::XCD_MAX_PAYLOAD
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // configuration write channel
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire xcd_pkg::t_cfg_idx i_cfg_index,
    input  wire logic [7:0]        i_cfg_data,
    // received byte channel
    input  wire logic              i_rx_valid,
    output logic                   o_rx_ready,
    input  wire logic [7:0]        i_rx_byte,
    // result channel
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output xcd_pkg::t_kind         o_frame_kind,
    output logic                   o_status,
    output logic [4:0]             o_byte_index,
    output logic [7:0]             o_payload_byte,
    output logic                   o_last
);
    import xcd_pkg::*;

    localparam int unsigned CAP =
        (MAX_PAYLOAD > XCD_RESULT_LIMIT) ? XCD_RESULT_LIMIT : MAX_PAYLOAD;
    localparam int unsigned AW  = (CAP > 1) ? $clog2(CAP) : 1;

    localparam logic [1:0] S_RX = 2'd0;
    localparam logic [1:0] S_RD = 2'd1;
    localparam logic [1:0] S_LD = 2'd2;

    logic [1:0] r_state, n_state;
    logic [5:0] r_count, n_count;
    t_kind      r_kind, n_kind;
    logic [7:0] r_parity, n_parity;
    logic [5:0] r_len, n_len;
    logic [5:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    t_kind      r_out_kind, n_out_kind;
    logic       r_out_status, n_out_status;
    logic [4:0] r_out_index, n_out_index;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_last, n_out_last;

    t_cfg_view  view;
    logic       mem_we, mem_re;
    logic [7:0] mem_rdata;
    logic [5:0] got;
    logic       is_ck, slot_free, rx_fire, idx_last;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    xcd_cfg #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (i_cfg_valid & o_cfg_ready),
        .i_index   (i_cfg_index),
        .i_data    (i_cfg_data),
        .i_rx_byte (i_rx_byte),
        .i_kind    (r_kind),
        .o_view    (view)
    );

    // payload store; writes only in S_RX, reads only in S_RD, so no overlap
    xcd_store #(
        .DEPTH(CAP),
        .AW   (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (got[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_re    (mem_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // receive phase decode
    assign got       = r_count - 6'd1;
    assign is_ck     = (r_count != 6'd0) && (got >= view.len);
    assign slot_free = !r_out_valid || i_res_ready;
    assign o_rx_ready = (r_state == S_RX) && !(is_ck && !slot_free);
    assign rx_fire   = i_rx_valid && o_rx_ready;
    assign idx_last  = ((r_idx + 6'd1) == r_len);

    // next state
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_kind       = r_kind;
        n_parity     = r_parity;
        n_len        = r_len;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !i_res_ready;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_byte   = r_out_byte;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_re       = 1'b0;

        unique case (r_state)
            S_RX: begin
                if (rx_fire) begin
                    if (r_count == 6'd0) begin
                        // hunt for a start code
                        if (view.hit) begin
                            n_kind   = view.kind;
                            n_parity = i_rx_byte;
                            n_count  = 6'd1;
                        end
                    end else if (!is_ck) begin
                        // payload byte
                        mem_we   = 1'b1;
                        n_parity = r_parity ^ i_rx_byte;
                        n_count  = r_count + 6'd1;
                    end else begin
                        // checksum byte
                        n_count  = 6'd0;
                        n_parity = 8'd0;
                        if (r_parity != i_rx_byte) begin
                            n_out_valid  = 1'b1;
                            n_out_kind   = r_kind;
                            n_out_status = ST_BAD_SUM;
                            n_out_index  = 5'd0;
                            n_out_byte   = 8'd0;
                            n_out_last   = 1'b1;
                        end else begin
                            n_len   = view.len;
                            n_idx   = 6'd0;
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_LD;
            end
            S_LD: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_kind;
                    n_out_status = ST_GOOD;
                    n_out_index  = r_idx[4:0];
                    n_out_byte   = mem_rdata;
                    n_out_last   = idx_last;
                    if (idx_last) begin
                        n_state = S_RX;
                    end else begin
                        n_idx   = r_idx + 6'd1;
                        n_state = S_RD;
                    end
                end
            end
            default: n_state = S_RX;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RX;
            r_count     <= 6'd0;
            r_kind      <= KIND_MODE;
            r_parity    <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_kind      <= n_kind;
            r_parity    <= n_parity;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_byte   <= n_out_byte;
        r_out_last   <= n_out_last;
    end

    assign o_res_valid    = r_out_valid;
    assign o_frame_kind   = r_out_kind;
    assign o_status       = r_out_status;
    assign o_byte_index   = r_out_index;
    assign o_payload_byte = r_out_byte;
    assign o_last         = r_out_last;

    // checks
    a_no_rx_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_RX) |-> !o_rx_ready)
        else $error("byte taken while emitting a frame");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_status == ST_BAD_SUM)) |->
        (o_last && (o_byte_index == 5'd0) && (o_payload_byte == 8'd0)))
        else $error("malformed checksum error result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 6'(CAP + 1))
        else $error("byte count past payload limit");

    a_load_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LD) |-> (($past(r_state) == S_RD) || ($past(r_state) == S_LD)))
        else $error("output load without a store read");

endmodule
`default_nettype wire

// ===== rtl/xcd_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xcd_store
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module xcd_store #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/xcd_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// xcd_cfg
// Configuration registers, start code match and payload length selection.
// ----------------------------------------------------------------------------
module xcd_cfg #(
    parameter int unsigned MAX_PAYLOAD = xcd_pkg::XCD_MAX_PAYLOAD
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire xcd_pkg::t_cfg_idx i_index,
    input  wire logic [7:0]        i_data,
    input  wire logic [7:0]        i_rx_byte,
    input  wire xcd_pkg::t_kind    i_kind,
    output xcd_pkg::t_cfg_view     o_view
);
    import xcd_pkg::*;

    localparam int unsigned CAP =
        (MAX_PAYLOAD > XCD_RESULT_LIMIT) ? XCD_RESULT_LIMIT : MAX_PAYLOAD;
    localparam logic [5:0] CAP6 = 6'(CAP);

    logic [7:0] r_mode_code, r_servo_code, r_gain_code;
    logic [5:0] r_mode_len, r_servo_len, r_gain_len;
    logic [5:0] sel_len;

    // register writes; indexes past the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_code  <= RST_MODE_CODE;
            r_servo_code <= RST_SERVO_CODE;
            r_gain_code  <= RST_GAIN_CODE;
            r_mode_len   <= RST_LENGTH;
            r_servo_len  <= RST_LENGTH;
            r_gain_len   <= RST_LENGTH;
        end else if (i_we) begin
            unique case (i_index)
                REG_MODE_CODE:    r_mode_code  <= i_data;
                REG_SERVO_CODE:   r_servo_code <= i_data;
                REG_GAIN_CODE:    r_gain_code  <= i_data;
                REG_MODE_LENGTH:  r_mode_len   <= i_data[5:0];
                REG_SERVO_LENGTH: r_servo_len  <= i_data[5:0];
                REG_GAIN_LENGTH:  r_gain_len   <= i_data[5:0];
                default: ;
            endcase
        end
    end

    // live length of the open kind
    always_comb begin
        unique case (i_kind)
            KIND_MODE:  sel_len = r_mode_len;
            KIND_SERVO: sel_len = r_servo_len;
            default:    sel_len = r_gain_len;
        endcase
    end

    // start code match, mode before servo before gain; clamped length
    always_comb begin
        o_view.hit  = 1'b1;
        o_view.kind = KIND_MODE;
        if (i_rx_byte == r_mode_code) begin
            o_view.kind = KIND_MODE;
        end else if (i_rx_byte == r_servo_code) begin
            o_view.kind = KIND_SERVO;
        end else if (i_rx_byte == r_gain_code) begin
            o_view.kind = KIND_GAIN;
        end else begin
            o_view.hit = 1'b0;
        end
        o_view.len = clamp_len(sel_len, CAP6);
    end

endmodule
`default_nettype wire
